FILE: hdl/gray_scott_line_step_macros.svh
// Assertion macros used by the checker file.
// Each macro clocks on i_clk and is disabled while i_rst_n is low.
`ifndef GRAY_SCOTT_LINE_STEP_MACROS_SVH
`define GRAY_SCOTT_LINE_STEP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GSL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GSL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/gsl_pkg.sv
package gsl_pkg;

    typedef logic [15:0]        t_q15;
    typedef logic signed [32:0] t_mul_op;
    typedef logic signed [65:0] t_mul_prod;

    localparam logic [16:0] ONE_Q15    = 17'd32768;
    localparam logic [31:0] HASH_MUL_A = 32'h7feb352d;
    localparam logic [31:0] HASH_MUL_B = 32'h846ca68b;
    localparam logic [28:0] NOISE_DIV  = 29'd102300;
    localparam logic [28:0] NOISE_BIAS = 29'd51150;
    // floor(2^40 / 102300), quotient estimate is low by at most one
    localparam logic [31:0] NOISE_RECIP = 32'd10747914;

    // command codes
    localparam logic [1:0] CMD_RESEED = 2'd0;
    localparam logic [1:0] CMD_STEP   = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // edge rules
    localparam logic [1:0] BND_CLAMP   = 2'd0;
    localparam logic [1:0] BND_WRAP    = 2'd1;
    localparam logic [1:0] BND_REFLECT = 2'd2;

    // seed patterns
    localparam logic [1:0] SEED_CENTER = 2'd0;
    localparam logic [1:0] SEED_SINGLE = 2'd1;
    localparam logic [1:0] SEED_WIDE   = 2'd2;
    localparam logic [1:0] SEED_NOISE  = 2'd3;

    // register indexes
    localparam logic [2:0] CFG_BOUNDARY = 3'd0;
    localparam logic [2:0] CFG_DT       = 3'd1;
    localparam logic [2:0] CFG_ITERS    = 3'd2;
    localparam logic [2:0] CFG_SEED     = 3'd3;
    localparam logic [2:0] CFG_FEED     = 3'd4;
    localparam logic [2:0] CFG_KILL     = 3'd5;

endpackage

FILE: hdl/gsl_mul.sv
module gsl_mul (
    input  logic              i_clk,
    input  gsl_pkg::t_mul_op  i_a,
    input  gsl_pkg::t_mul_op  i_b,
    output gsl_pkg::t_mul_prod o_p
);
    import gsl_pkg::*;

    t_mul_prod r_p;

    // register every product
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

FILE: hdl/gray_scott_line_step.sv
// Gray-Scott reaction-diffusion over a line of CELLS cells, u and v in Q1.15.
// Input channel (i_valid/o_ready) takes one command word: i_mode and
// i_cell_index. Output channel (o_valid/i_ready) returns one word per
// command: u and v of the addressed cell after the command, or zero for an
// index at or beyond CELLS.
// Configuration is a plain write port (i_cfg_wr_en, i_cfg_addr, i_cfg_wdata);
// written only while no command is in progress, a user rule not enforced here.
// All arithmetic goes through one registered multiplier under a sequencer,
// and u and v live in single-port-read memories; the cell loop sets the time:
//   read:   one memory read of the addressed cell
//   reseed: one write per cell, with more work per cell for the noise seed
//           (hash multiplies, a reciprocal multiply and a back-multiply per cell)
//   step:   per iteration, a window preload, then six multiplies per cell
// o_ready is high only while the sequencer is idle; one command runs at a time.
// After reset the block runs a CELLS-long seeding pass that loads the
// center-13 seed, and accepts no command until it ends.
// A result held by a stalled receiver stays put; the next command is taken
// meanwhile and its result waits until the held word is taken.
module gray_scott_line_step #(
    parameter int CELLS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_mode,
    input  logic [7:0]        i_cell_index,
    output logic              o_valid,
    input  logic              i_ready,
    output gsl_pkg::t_q15     o_u_level,
    output gsl_pkg::t_q15     o_v_level,
    input  logic              i_cfg_wr_en,
    input  logic [2:0]        i_cfg_addr,
    input  logic [15:0]       i_cfg_wdata
);
    import gsl_pkg::*;

    localparam int AW  = $clog2(CELLS);
    localparam int MID = CELLS / 2;
    localparam logic [AW-1:0] LAST = AW'(CELLS - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_SEED, S_H0, S_H1, S_H2, S_DIV, S_DMUL, S_DFIX, S_SWR,
        S_P0, S_P1, S_P2, S_A, S_B, S_C, S_D, S_E, S_F, S_G,
        S_RQ, S_OUT
    } t_state;

    // configuration
    logic [1:0]  r_bmode;
    logic [15:0] r_dt;
    logic [2:0]  r_iters;
    logic [1:0]  r_seed;
    logic [15:0] r_feed;
    logic [15:0] r_kill;

    // sequencer
    t_state      r_state;
    logic        r_init;
    logic [1:0]  r_pat;
    logic [2:0]  r_iter;
    logic [AW-1:0] r_cell;
    logic [AW-1:0] r_idx;
    logic        r_inrange;

    // noise quotient
    logic [28:0] r_rem;
    logic [11:0] r_q;

    // cell window, old values
    t_q15 r_lu, r_lv, r_cu, r_cv, r_ru, r_rv, r_fu0, r_fv0;
    t_q15 r_uvv, r_fu, r_unew;
    logic [17:0] r_kv;

    // output word
    logic r_ovalid;
    t_q15 r_ou, r_ov;

    // memories
    t_q15 mem_u [CELLS];
    t_q15 mem_v [CELLS];
    t_q15 r_rdu, r_rdv;
    logic [AW-1:0] w_raddr, w_waddr;
    logic          w_we;
    t_q15          w_wu, w_wv;

    // shared multiplier
    t_mul_op   w_ma, w_mb;
    t_mul_prod w_p;

    // arithmetic
    t_mul_prod          w_rnd15, w_rnd14k, w_sh14, w_sh15, w_usum, w_vsum;
    logic signed [20:0] w_du;
    logic signed [21:0] w_dv;
    logic [31:0]        w_x1, w_x2;
    logic [16:0]        w_fk;
    logic [28:0]        w_nn;
    t_q15               w_vnew, w_su, w_sv;
    logic [12:0]        w_qr;
    logic               w_span;
    int                 w_half;
    int                 w_ci;

    gsl_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_p)
    );

    function automatic t_q15 sat_q15(input t_mul_prod x);
        t_q15 res;
        if (x < 0) begin
            res = '0;
        end else if (x > $signed({49'b0, ONE_Q15})) begin
            res = ONE_Q15[15:0];
        end else begin
            res = x[15:0];
        end
        return res;
    endfunction

    // rounding and update terms
    always_comb begin
        w_rnd15  = (w_p + 66'sd16384) >>> 15;
        w_rnd14k = (w_p + 66'sd8192) >>> 14;
        w_sh14   = (w_p + 66'sd8192) >>> 14;
        w_sh15   = (w_p + 66'sd16384) >>> 15;
        w_du = $signed({5'b0, r_lu}) + $signed({5'b0, r_ru})
             - $signed({4'b0, r_cu, 1'b0}) - $signed({5'b0, r_uvv})
             + $signed({5'b0, r_fu});
        w_dv = $signed({6'b0, r_lv}) + $signed({6'b0, r_rv})
             - $signed({5'b0, r_cv, 1'b0}) + $signed({5'b0, r_uvv, 1'b0})
             - $signed({4'b0, r_kv});
        w_usum = $signed({50'b0, r_cu}) + w_sh14;
        w_vsum = $signed({50'b0, r_cv}) + w_sh15;
        w_vnew = sat_q15(w_vsum);
        w_fk   = {1'b0, r_feed} + {1'b0, r_kill};
        w_x1   = w_p[31:0] ^ {15'b0, w_p[31:15]};
        w_x2   = w_p[31:0] ^ {16'b0, w_p[31:16]};
        w_nn   = {1'b0, w_x2[9:0], 18'b0} + NOISE_BIAS;
    end

    // seed value of the current cell
    always_comb begin
        unique case (r_pat)
            SEED_SINGLE: w_half = 0;
            SEED_WIDE:   w_half = 12;
            SEED_CENTER: w_half = 6;
            SEED_NOISE:  w_half = 6;
        endcase
        w_ci   = int'({1'b0, r_cell});
        w_span = (w_ci >= MID - w_half) && (w_ci <= MID + w_half);
        w_qr   = {1'b0, r_q} + 13'd2;
        if (w_span) begin
            w_su = '0;
            w_sv = ONE_Q15[15:0];
        end else if (r_pat == SEED_NOISE) begin
            w_su = 16'(ONE_Q15 - {6'b0, w_qr[12:2]});
            w_sv = {4'b0, r_q};
        end else begin
            w_su = ONE_Q15[15:0];
            w_sv = '0;
        end
    end

    // multiplier operands, read address and write port by state
    always_comb begin
        w_ma    = '0;
        w_mb    = '0;
        w_raddr = r_cell;
        w_we    = 1'b0;
        w_waddr = r_cell;
        w_wu    = w_su;
        w_wv    = w_sv;
        unique case (r_state)
            S_H0: begin
                w_ma = t_mul_op'({{(32-AW){1'b0}}, r_cell});
                w_mb = {1'b0, HASH_MUL_A};
            end
            S_H1: begin
                w_ma = {1'b0, w_x1};
                w_mb = {1'b0, HASH_MUL_B};
            end
            S_H2: begin
                w_ma = {4'b0, w_nn};
                w_mb = {1'b0, NOISE_RECIP};
            end
            S_DMUL: begin
                w_ma = {21'b0, r_q};
                w_mb = {4'b0, NOISE_DIV};
            end
            S_SWR: w_we = 1'b1;
            S_P0:  w_raddr = '0;
            S_P1: begin
                priority case (r_bmode)
                    BND_WRAP:    w_raddr = LAST;
                    BND_REFLECT: w_raddr = AW'(1);
                    default:     w_raddr = '0;
                endcase
            end
            S_A: begin
                w_raddr = (r_cell == LAST) ? r_cell : r_cell + AW'(1);
                w_ma = {17'b0, r_cu};
                w_mb = {17'b0, r_cv};
            end
            S_B: begin
                w_ma = {16'b0, w_rnd15[16:0]};
                w_mb = {17'b0, r_cv};
            end
            S_C: begin
                w_ma = {17'b0, r_feed};
                w_mb = {16'b0, ONE_Q15 - {1'b0, r_cu}};
            end
            S_D: begin
                w_ma = {16'b0, w_fk};
                w_mb = {17'b0, r_cv};
            end
            S_E: begin
                w_ma = t_mul_op'(w_du);
                w_mb = {17'b0, r_dt};
            end
            S_F: begin
                w_ma = t_mul_op'(w_dv);
                w_mb = {17'b0, r_dt};
            end
            S_G: begin
                w_we = 1'b1;
                w_wu = r_unew;
                w_wv = w_vnew;
            end
            S_RQ, S_OUT: w_raddr = r_idx;
            default: ;
        endcase
    end

    // line memories
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_u[w_waddr] <= w_wu;
            mem_v[w_waddr] <= w_wv;
        end
        r_rdu <= mem_u[w_raddr];
        r_rdv <= mem_v[w_raddr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bmode <= BND_CLAMP;
            r_dt    <= 16'd14746;
            r_iters <= 3'd1;
            r_seed  <= SEED_CENTER;
            r_feed  <= 16'd1245;
            r_kill  <= 16'd2064;
        end else if (i_cfg_wr_en) begin
            priority case (i_cfg_addr)
                CFG_BOUNDARY: r_bmode <= i_cfg_wdata[1:0];
                CFG_DT:       r_dt    <= i_cfg_wdata;
                CFG_ITERS:    r_iters <= i_cfg_wdata[2:0];
                CFG_SEED:     r_seed  <= i_cfg_wdata[1:0];
                CFG_FEED:     r_feed  <= i_cfg_wdata;
                CFG_KILL:     r_kill  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer, window and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SEED;
            r_init   <= 1'b1;
            r_pat    <= SEED_CENTER;
            r_cell   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_idx     <= AW'(i_cell_index);
                        r_inrange <= ({24'b0, i_cell_index} < 32'(CELLS));
                        r_cell    <= '0;
                        r_iter    <= r_iters;
                        priority case (i_mode)
                            CMD_RESEED: begin
                                r_pat   <= r_seed;
                                r_state <= S_SEED;
                            end
                            CMD_STEP:
                                r_state <= (r_iters == 3'd0) ? S_RQ : S_P0;
                            default: r_state <= S_RQ;
                        endcase
                    end
                end
                S_SEED: r_state <= (r_pat == SEED_NOISE) ? S_H0 : S_SWR;
                S_H0:   r_state <= S_H1;
                S_H1:   r_state <= S_H2;
                S_H2: begin
                    r_rem   <= w_nn;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // quotient estimate, low by at most one
                    r_q     <= w_p[51:40];
                    r_state <= S_DMUL;
                end
                S_DMUL: r_state <= S_DFIX;
                S_DFIX: begin
                    // bump the estimate when the remainder is still a divisor or more
                    if (r_rem - w_p[28:0] >= NOISE_DIV) begin
                        r_q <= r_q + 12'd1;
                    end
                    r_state <= S_SWR;
                end
                S_SWR: begin
                    if (r_cell == LAST) begin
                        r_init  <= 1'b0;
                        r_state <= r_init ? S_IDLE : S_RQ;
                    end else begin
                        r_cell  <= r_cell + AW'(1);
                        r_state <= S_SEED;
                    end
                end
                S_P0: r_state <= S_P1;
                S_P1: begin
                    r_cu    <= r_rdu;
                    r_cv    <= r_rdv;
                    r_fu0   <= r_rdu;
                    r_fv0   <= r_rdv;
                    r_state <= S_P2;
                end
                S_P2: begin
                    if (r_bmode == BND_WRAP || r_bmode == BND_REFLECT) begin
                        r_lu <= r_rdu;
                        r_lv <= r_rdv;
                    end else begin
                        r_lu <= r_cu;
                        r_lv <= r_cv;
                    end
                    r_state <= S_A;
                end
                S_A: r_state <= S_B;
                S_B: begin
                    // pick the right neighbor, old value
                    if (r_cell != LAST) begin
                        r_ru <= r_rdu;
                        r_rv <= r_rdv;
                    end else if (r_bmode == BND_WRAP) begin
                        r_ru <= r_fu0;
                        r_rv <= r_fv0;
                    end else if (r_bmode == BND_REFLECT) begin
                        r_ru <= r_lu;
                        r_rv <= r_lv;
                    end else begin
                        r_ru <= r_cu;
                        r_rv <= r_cv;
                    end
                    r_state <= S_C;
                end
                S_C: begin
                    r_uvv   <= w_rnd15[15:0];
                    r_state <= S_D;
                end
                S_D: begin
                    r_fu    <= w_rnd15[15:0];
                    r_state <= S_E;
                end
                S_E: begin
                    r_kv    <= w_rnd14k[17:0];
                    r_state <= S_F;
                end
                S_F: begin
                    r_unew  <= sat_q15(w_usum);
                    r_state <= S_G;
                end
                S_G: begin
                    // slide the window
                    r_lu <= r_cu;
                    r_lv <= r_cv;
                    r_cu <= r_ru;
                    r_cv <= r_rv;
                    if (r_cell == LAST) begin
                        r_cell <= '0;
                        r_iter <= r_iter - 3'd1;
                        r_state <= (r_iter == 3'd1) ? S_RQ : S_P0;
                    end else begin
                        r_cell  <= r_cell + AW'(1);
                        r_state <= S_A;
                    end
                end
                S_RQ: r_state <= S_OUT;
                S_OUT: begin
                    // hold until the output word is free
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_ou     <= r_inrange ? r_rdu : '0;
                        r_ov     <= r_inrange ? r_rdv : '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_ovalid;
    assign o_u_level = r_ou;
    assign o_v_level = r_ov;

endmodule

FILE: hdl/gsl_checker.sv
`include "gray_scott_line_step_macros.svh"

module gsl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_u_level,
    input logic [15:0] o_v_level
);

    // a word offered stays offered until taken
    `GSL_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid, "output word dropped")

    // an accepted command makes the sequencer busy
    `GSL_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready, "ready after accept")

    // levels stay saturated to 0..1
    `GSL_ASSERT_SAME(a_level_range, o_valid,
        (o_u_level <= 16'd32768) && (o_v_level <= 16'd32768), "level out of range")

endmodule

bind gray_scott_line_step gsl_checker u_gsl_checker (.*);

FILE: tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gsl_pkg::*;

    localparam int         LINE_CELLS   = 256;
    localparam int         IDLE_LIMIT   = 60000;
    localparam int         LONG_HOLD    = 400;
    localparam logic [1:0] CMD_NOP      = 2'd3;
    localparam logic [1:0] BND_SPARE    = 2'd3;
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        t_q15 u_level;
        t_q15 v_level;
    } cell_word_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_mode;
    logic [7:0]  i_cell_index;
    logic        o_valid;
    logic        i_ready;
    t_q15        o_u_level;
    t_q15        o_v_level;
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_addr;
    logic [15:0] i_cfg_wdata;

    gray_scott_line_step dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_cell_index (i_cell_index),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_u_level    (o_u_level),
        .o_v_level    (o_v_level),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // predicted line state and register copies
    logic [15:0] line_u [LINE_CELLS];
    logic [15:0] line_v [LINE_CELLS];
    logic [1:0]  edge_rule;
    logic [15:0] dt_q14;
    logic [2:0]  iter_count;
    logic [1:0]  seed_sel;
    logic [15:0] feed_q15;
    logic [15:0] kill_q15;

    cell_word_t  pending_words[$];
    int          err_count;
    int          idle_cycles;
    bit          gaps_on;
    bit          long_hold_req;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] noise_hash(input logic [31:0] x);
        logic [31:0] h;
        h = x ^ (x >> 16);
        h = h * 32'h7feb352d;
        h = h ^ (h >> 15);
        h = h * 32'h846ca68b;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic void seed_center_span(input int half);
        for (int i = LINE_CELLS / 2 - half; i <= LINE_CELLS / 2 + half; i++) begin
            if (i >= 0 && i < LINE_CELLS) begin
                line_u[i] = 16'd0;
                line_v[i] = 16'd32768;
            end
        end
    endfunction

    function automatic void load_seed();
        longint h;
        longint nv;
        for (int i = 0; i < LINE_CELLS; i++) begin
            line_u[i] = 16'd32768;
            line_v[i] = 16'd0;
        end
        case (seed_sel)
            SEED_SINGLE: seed_center_span(0);
            SEED_WIDE:   seed_center_span(12);
            SEED_NOISE: begin
                for (int i = 0; i < LINE_CELLS; i++) begin
                    h = noise_hash(i) & 32'd1023;
                    nv = (h * 262144 + 51150) / 102300;
                    line_v[i] = nv[15:0];
                    line_u[i] = 16'(32768 - ((nv + 2) >> 2));
                end
                seed_center_span(6);
            end
            default: seed_center_span(6);
        endcase
    endfunction

    function automatic logic [15:0] clip_q15(input longint x);
        if (x < 0) return 16'd0;
        if (x > 32768) return 16'd32768;
        return x[15:0];
    endfunction

    // one Euler update of the whole line from the old values
    function automatic void advance_line();
        logic [15:0] ou [LINE_CELLS];
        logic [15:0] ov [LINE_CELLS];
        longint uc, vc, ul, vl, ur, vr, uv, uvv, fu, kv, du, dv;
        ou = line_u;
        ov = line_v;
        for (int i = 0; i < LINE_CELLS; i++) begin
            uc = ou[i];
            vc = ov[i];
            if (i > 0) begin
                ul = ou[i-1];
                vl = ov[i-1];
            end else if (edge_rule == BND_WRAP) begin
                ul = ou[LINE_CELLS-1];
                vl = ov[LINE_CELLS-1];
            end else if (edge_rule == BND_REFLECT) begin
                ul = ou[1];
                vl = ov[1];
            end else begin
                ul = uc;
                vl = vc;
            end
            if (i < LINE_CELLS - 1) begin
                ur = ou[i+1];
                vr = ov[i+1];
            end else if (edge_rule == BND_WRAP) begin
                ur = ou[0];
                vr = ov[0];
            end else if (edge_rule == BND_REFLECT) begin
                ur = ou[LINE_CELLS-2];
                vr = ov[LINE_CELLS-2];
            end else begin
                ur = uc;
                vr = vc;
            end
            uv  = (uc * vc + 16384) >> 15;
            uvv = (uv * vc + 16384) >> 15;
            fu  = (longint'(feed_q15) * (32768 - uc) + 16384) >> 15;
            kv  = ((longint'(feed_q15) + longint'(kill_q15)) * vc + 8192) >> 14;
            du  = ul + ur - 2 * uc - uvv + fu;
            dv  = vl + vr - 2 * vc + 2 * uvv - kv;
            line_u[i] = clip_q15(uc + ((du * longint'(dt_q14) + 8192) >>> 14));
            line_v[i] = clip_q15(vc + ((dv * longint'(dt_q14) + 16384) >>> 15));
        end
    endfunction

    function automatic cell_word_t run_command(input logic [1:0] mode, input logic [7:0] idx);
        cell_word_t w;
        if (mode == CMD_RESEED) begin
            load_seed();
        end else if (mode == CMD_STEP) begin
            for (int k = 0; k < iter_count; k++) advance_line();
        end
        w.u_level = line_u[idx];
        w.v_level = line_v[idx];
        return w;
    endfunction

    // drive one command word and hold it until taken
    task automatic send_word(input logic [1:0] mode, input logic [7:0] idx);
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_cell_index <= idx;
        do @(posedge i_clk); while (!o_ready);
        pending_words.push_back(run_command(mode, idx));
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // drop valid and wait until every word is back and the block is idle
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0 || !o_ready) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] addr, input logic [15:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (addr)
            CFG_BOUNDARY: edge_rule  = data[1:0];
            CFG_DT:       dt_q14     = data;
            CFG_ITERS:    iter_count = data[2:0];
            CFG_SEED:     seed_sel   = data[1:0];
            CFG_FEED:     feed_q15   = data;
            CFG_KILL:     kill_q15   = data;
            default:      ;
        endcase
    endtask

    task automatic cfg_all(input logic [15:0] bnd, input logic [15:0] dt,
                           input logic [15:0] iters, input logic [15:0] seed,
                           input logic [15:0] feed, input logic [15:0] kill);
        cfg_write(CFG_BOUNDARY, bnd);
        cfg_write(CFG_DT, dt);
        cfg_write(CFG_ITERS, iters);
        cfg_write(CFG_SEED, seed);
        cfg_write(CFG_FEED, feed);
        cfg_write(CFG_KILL, kill);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        send_word(CMD_READ, 8'd0);
        send_word(CMD_READ, 8'd121);
        send_word(CMD_READ, 8'd122);
        send_word(CMD_READ, 8'd128);
        send_word(CMD_READ, 8'd134);
        send_word(CMD_READ, 8'd255);
        send_word(CMD_STEP, 8'd122);
        drain();
    endtask

    // extremes of registers and fields, every command, every seed and edge rule
    task automatic test_directed();
        cfg_all(BND_WRAP, 16'hFFFF, 16'd7, SEED_SINGLE, 16'd32768, 16'd0);
        send_word(CMD_RESEED, 8'd128);
        send_word(CMD_STEP, 8'd127);
        send_word(CMD_NOP, 8'd129);
        drain();
        cfg_all(BND_REFLECT, 16'd0, 16'd0, SEED_WIDE, 16'd0, 16'd32768);
        send_word(CMD_RESEED, 8'd116);
        send_word(CMD_STEP, 8'd140);
        send_word(CMD_READ, 8'd115);
        drain();
        cfg_all(BND_SPARE, 16'd14746, 16'hFFFF, SEED_NOISE, 16'hFFFF, 16'hFFFF);
        cfg_write(CFG_SPARE_LO, 16'hFFFF);
        cfg_write(CFG_SPARE_HI, 16'h5A5A);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        send_word(CMD_RESEED, 8'd255);
        send_word(CMD_READ, 8'd0);
        send_word(CMD_STEP, 8'd0);
        drain();
        cfg_all(BND_CLAMP, 16'd16384, 16'd1, SEED_CENTER, 16'd1245, 16'd2064);
        send_word(CMD_RESEED, 8'd170);
        send_word(CMD_STEP, 8'd85);
        send_word(CMD_STEP, 8'd255);
        send_word(CMD_READ, 8'd128);
        drain();
    endtask

    function automatic logic [15:0] pick_rate();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'd32768;
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 4000));
        endcase
    endfunction

    task automatic random_config();
        logic [15:0] dt;
        logic [15:0] iters;
        case ($urandom_range(0, 4))
            0:       dt = 16'd0;
            1:       dt = 16'hFFFF;
            default: dt = 16'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       iters = 16'($urandom_range(0, 7)) | 16'($urandom & 16'hFFF8);
            1:       iters = 16'd2;
            default: iters = 16'd1;
        endcase
        cfg_all(16'($urandom), dt, iters, 16'($urandom), pick_rate(), pick_rate());
    endtask

    task automatic random_commands(input int count);
        int r;
        logic [1:0] mode;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 64)      mode = CMD_READ;
            else if (r < 76) mode = CMD_STEP;
            else if (r < 90) mode = CMD_RESEED;
            else             mode = CMD_NOP;
            send_word(mode, 8'($urandom));
        end
        drain();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 10; p++) begin
            random_config();
            random_commands(95);
        end
    endtask

    // stall the result side for a long stretch while commands keep coming
    task automatic test_backpressure();
        long_hold_req = 1'b1;
        for (int n = 0; n < 6; n++) send_word(CMD_READ, 8'($urandom));
        send_word(CMD_STEP, 8'($urandom));
        drain();
    endtask

    // result side: random stall bursts, and the long hold on request
    initial begin
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
                i_ready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // compare each returned word with the oldest expectation
    always @(posedge i_clk) begin
        cell_word_t exp_w;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word u=%h v=%h", $time, o_u_level, o_v_level);
                err_count++;
            end else begin
                exp_w = pending_words.pop_front();
                if (o_u_level !== exp_w.u_level) begin
                    $display("%0t: u_level expected %h actual %h",
                             $time, exp_w.u_level, o_u_level);
                    err_count++;
                end
                if (o_v_level !== exp_w.v_level) begin
                    $display("%0t: v_level expected %h actual %h",
                             $time, exp_w.v_level, o_v_level);
                    err_count++;
                end
            end
        end
    end

    // watchdog: count cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_mode        = CMD_READ;
        i_cell_index  = 8'd0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_addr    = CFG_BOUNDARY;
        i_cfg_wdata   = 16'd0;
        err_count     = 0;
        idle_cycles   = 0;
        gaps_on       = 1'b1;
        long_hold_req = 1'b0;
        edge_rule     = BND_CLAMP;
        dt_q14        = 16'd14746;
        iter_count    = 3'd1;
        seed_sel      = SEED_CENTER;
        feed_q15      = 16'd1245;
        kill_q15      = 16'd2064;
        load_seed();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // hold off until the seeding pass after reset is done
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);

        test_reset_state();
        test_directed();
        test_backpressure();
        test_random_phases();
        // last part without idling on either side
        gaps_on = 1'b0;
        random_config();
        random_commands(150);

        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
